@@ rtl/bez_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bez_pkg - shared types and constants for the easing curve evaluator
// Field widths, sequencer codes and the control bundle for the shared
// arithmetic unit.
// ----------------------------------------------------------------------------
package bez_pkg;

  localparam int CTRL_W   = 7;
  localparam int PROG_W   = 17;
  localparam int EASE_W   = 17;
  localparam int EASE_MAX = 65536;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_DIVA,
    ST_DIVB,
    ST_CHECK,
    ST_FIN
  } state_t;

  // Micro-operations of one curve evaluation
  typedef enum logic [2:0] {
    UOP_TT,
    UOP_SS,
    UOP_B3,
    UOP_B1,
    UOP_B2,
    UOP_W1,
    UOP_W2
  } uop_t;

  // Enables for the shared multiply / divide-by-127 unit
  typedef struct packed {
    logic mul_en;
    logic div_en;
  } arith_ctl_t;

endpackage

@@ rtl/bez_item_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bez_item_if - input item channel
// Valid/ready channel carrying two control points and the curve input.
// ----------------------------------------------------------------------------
interface bez_item_if;
  import bez_pkg::*;

  logic              valid;
  logic              ready;
  logic [CTRL_W-1:0] ctrl_ax;
  logic [CTRL_W-1:0] ctrl_ay;
  logic [CTRL_W-1:0] ctrl_bx;
  logic [CTRL_W-1:0] ctrl_by;
  logic [PROG_W-1:0] progress;

  modport source (
    output valid, ctrl_ax, ctrl_ay, ctrl_bx, ctrl_by, progress,
    input  ready
  );

  modport sink (
    input  valid, ctrl_ax, ctrl_ay, ctrl_bx, ctrl_by, progress,
    output ready
  );

endinterface

@@ rtl/bez_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bez_result_if - result channel
// Valid/ready channel carrying the eased curve output.
// ----------------------------------------------------------------------------
interface bez_result_if;
  import bez_pkg::*;

  logic              valid;
  logic              ready;
  logic [EASE_W-1:0] eased;

  modport source (
    output valid, eased,
    input  ready
  );

  modport sink (
    input  valid, eased,
    output ready
  );

endinterface

@@ rtl/bezier_easing_curve_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_easing_curve_eval - cubic Bezier easing curve by bisection
// Finds t with Bx(t) = x by bisection and returns By at the last t evaluated.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    ctrl_ax, ctrl_ay, ctrl_bx, ctrl_by, progress
//   out_ch   out  valid / ready    eased
//
// One curve evaluation runs on the shared multiplier: five rounded products
// (ST_MUL then ST_RND), two weighted terms (ST_MUL, ST_DIVA, ST_DIVB)
// and one compare/update step (ST_CHECK). An item runs k search steps
// (1..SEARCH_STEPS, 16 by default), then a final pass of the weighted terms
// with the y control points. Input is taken only while the sequencer is idle; a
// result waits in the output register while the next item is accepted, and
// the sequencer holds its final step until that register is free.
// Reset is synchronous and clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module bezier_easing_curve_eval #(
  parameter int SEARCH_STEPS = 16,
  parameter int T_FRAC_BITS  = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  bez_item_if.sink     in_ch,
  bez_result_if.source out_ch
);
  import bez_pkg::*;

  localparam int F      = T_FRAC_BITS;
  localparam int BW     = F + 2;
  localparam int SUMW   = F + 3;
  localparam int XW     = F + 1;
  localparam int IW     = $clog2(SEARCH_STEPS);
  localparam int TOL_SH = (F >= 20) ? (F - 20) : 0;
  localparam logic [IW-1:0] LAST_ITER = IW'(SEARCH_STEPS - 1);

  state_t     state_r, state_nxt;
  uop_t       uop_r;
  arith_ctl_t ctl;

  logic [CTRL_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic [XW-1:0]     xq_r;
  logic [F-1:0]      t_r;
  logic [F-2:0]      step_r;
  logic [IW-1:0]     iter_r;
  logic              final_r;
  logic [F-1:0]      tt_r, ss_r, b3_r;
  logic [BW-1:0]     b1_r, b2_r, w1_r, w2_r;
  logic              out_valid_r;
  logic [EASE_W-1:0] out_eased_r;

  logic [F:0]        s_full;
  logic [F-1:0]      s_val;
  logic [BW-1:0]     op_a;
  logic [F-1:0]      op_b;
  logic [F-1:0]      rnd;
  logic [BW-1:0]     rnd_x3;
  logic [BW-1:0]     quo;
  logic [SUMW-1:0]   fx;
  logic [SUMW-1:0]   xq_ext;
  logic [SUMW-1:0]   diff;
  logic              fx_gt;
  logic              search_done;
  logic [SUMW-1:0]   ysum;
  logic [SUMW-1:0]   yq;
  logic [EASE_W-1:0] y_sat;
  logic              in_fire;
  logic              out_fire;
  logic              out_free;

  bez_arith #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_arith (
    .clk   (clk),
    .ctl   (ctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .rnd_o (rnd),
    .quo_o (quo)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.eased = out_eased_r;

  assign s_full = {1'b1, {F{1'b0}}} - {1'b0, t_r};
  assign s_val  = s_full[F-1:0];
  assign rnd_x3 = {2'b00, rnd} + {1'b0, rnd, 1'b0};

  // Search compare
  assign fx          = SUMW'(w1_r) + SUMW'(w2_r) + SUMW'(b3_r);
  assign xq_ext      = SUMW'(xq_r);
  assign fx_gt       = fx > xq_ext;
  assign diff        = fx_gt ? (fx - xq_ext) : (xq_ext - fx);
  assign search_done = ((diff >> TOL_SH) == '0) || (iter_r == LAST_ITER);

  // Output scaling and saturation
  assign ysum  = fx + (SUMW'(1) << (F - 17));
  assign yq    = ysum >> (F - 16);
  assign y_sat = (yq > SUMW'(EASE_MAX)) ? EASE_W'(EASE_MAX) : yq[EASE_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_MUL;
      ST_MUL: begin
        if (uop_r == UOP_W1 || uop_r == UOP_W2) state_nxt = ST_DIVA;
        else                                    state_nxt = ST_RND;
      end
      ST_RND:   state_nxt = ST_MUL;
      ST_DIVA:  state_nxt = ST_DIVB;
      ST_DIVB: begin
        priority if (uop_r == UOP_W1) state_nxt = ST_MUL;
        else if (final_r)             state_nxt = ST_FIN;
        else                          state_nxt = ST_CHECK;
      end
      ST_CHECK: state_nxt = ST_MUL;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, unit enables, operand select
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    ctl.mul_en  = (state_r == ST_MUL);
    ctl.div_en  = (state_r == ST_DIVA);
    unique case (uop_r)
      UOP_TT: begin op_a = BW'(t_r);  op_b = t_r;  end
      UOP_SS: begin op_a = BW'(s_val); op_b = s_val; end
      UOP_B3: begin op_a = BW'(tt_r); op_b = t_r;  end
      UOP_B1: begin op_a = BW'(ss_r); op_b = t_r;  end
      UOP_B2: begin op_a = BW'(s_val); op_b = tt_r; end
      UOP_W1: begin op_a = b1_r; op_b = F'(final_r ? ay_r : ax_r); end
      UOP_W2: begin op_a = b2_r; op_b = F'(final_r ? by_r : bx_r); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      uop_r       <= UOP_TT;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            uop_r   <= UOP_TT;
            final_r <= 1'b0;
          end
        end
        ST_RND: begin
          unique case (uop_r)
            UOP_TT:  uop_r <= UOP_SS;
            UOP_SS:  uop_r <= UOP_B3;
            UOP_B3:  uop_r <= UOP_B1;
            UOP_B1:  uop_r <= UOP_B2;
            default: uop_r <= UOP_W1;
          endcase
        end
        ST_DIVB: begin
          if (uop_r == UOP_W1) uop_r <= UOP_W2;
        end
        ST_CHECK: begin
          if (search_done) begin
            uop_r   <= UOP_W1;
            final_r <= 1'b1;
          end else begin
            uop_r <= UOP_TT;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r   <= in_ch.ctrl_ax;
      ay_r   <= in_ch.ctrl_ay;
      bx_r   <= in_ch.ctrl_bx;
      by_r   <= in_ch.ctrl_by;
      xq_r   <= {in_ch.progress, {(F-16){1'b0}}};
      t_r    <= {1'b1, {(F-1){1'b0}}};
      step_r <= {1'b1, {(F-2){1'b0}}};
      iter_r <= '0;
    end
    if (state_r == ST_RND) begin
      unique case (uop_r)
        UOP_TT:  tt_r <= rnd;
        UOP_SS:  ss_r <= rnd;
        UOP_B3:  b3_r <= rnd;
        UOP_B1:  b1_r <= rnd_x3;
        default: b2_r <= rnd_x3;
      endcase
    end
    if (state_r == ST_DIVB) begin
      if (uop_r == UOP_W1) w1_r <= quo;
      else                 w2_r <= quo;
    end
    // Move t by the current step; the step halves and drops to zero past t's LSB
    if (state_r == ST_CHECK && !search_done) begin
      if (fx_gt) t_r <= t_r - F'(step_r);
      else       t_r <= t_r + F'(step_r);
      step_r <= step_r >> 1;
      iter_r <= iter_r + IW'(1);
    end
    if (state_r == ST_FIN && out_free) begin
      out_eased_r <= y_sat;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_MUL && uop_r == UOP_TT && !final_r))
    else $error("accepted item did not start a curve evaluation");

  a_t_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (t_r != '0))
    else $error("curve parameter left the open unit interval");

  a_last_step_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && iter_r == LAST_ITER) |=> (final_r && uop_r == UOP_W1))
    else $error("search ran past its last step");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ch.ready) |=>
      (state_r == ST_FIN && $stable(out_eased_r)))
    else $error("pending result overwritten");
`endif

endmodule

@@ rtl/bez_arith.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bez_arith - shared multiplier with rounding and divide-by-127 stages
// One registered multiplier; a rounded Q0.F view of the product, and a
// two-stage constant division (b*c + 63) / 127 taken from the product.
// ----------------------------------------------------------------------------
module bez_arith #(
  parameter int T_FRAC_BITS = 24
) (
  input  logic                    clk,
  input  bez_pkg::arith_ctl_t     ctl,
  input  logic [T_FRAC_BITS+1:0]  op_a,
  input  logic [T_FRAC_BITS-1:0]  op_b,
  output logic [T_FRAC_BITS-1:0]  rnd_o,
  output logic [T_FRAC_BITS+1:0]  quo_o
);
  import bez_pkg::*;

  localparam int F         = T_FRAC_BITS;
  localparam int BW        = F + 2;
  localparam int PW        = 2 * F + 2;
  localparam int NW        = F + 9;
  localparam int DIV_TERMS = (NW - 1) / 7;

  logic [PW-1:0] prod_r;
  logic [PW-1:0] rsum;
  logic [NW-1:0] num;
  logic [NW-1:0] q0;
  logic [NW-1:0] num_r;
  logic [NW-1:0] q0_r;
  logic [NW-1:0] q0_x127;
  logic [NW-1:0] rem;
  logic [16:0]   rem_p1;
  logic [16:0]   corr;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= PW'(op_a) * PW'(op_b);
    end
  end

  // Round half up back to Q0.F
  assign rsum  = prod_r + (PW'(1) << (F - 1));
  assign rnd_o = rsum[2*F-1:F];

  // Lower bound of num/127 as a sum of shifted copies; off by at most a few units
  assign num = prod_r[NW-1:0] + NW'(63);

  always_comb begin
    q0 = '0;
    for (int j = 1; j <= DIV_TERMS; j++) begin
      q0 = q0 + (num >> (7 * j));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_en) begin
      num_r <= num;
      q0_r  <= q0;
    end
  end

  // Remainder stays below 127*(DIV_TERMS+2); fix the quotient with (r+1)*129 >> 14
  assign q0_x127 = (q0_r << 7) - q0_r;
  assign rem     = num_r - q0_x127;
  assign rem_p1  = {7'd0, rem[9:0]} + 17'd1;
  assign corr    = ((rem_p1 << 7) + rem_p1) >> 14;
  assign quo_o   = q0_r[BW-1:0] + BW'(corr);

endmodule
